[hw/rtl/deq_pkg.sv]
package deq_pkg;

    localparam int DEPTH_DEFAULT = 1024;
    localparam int REQ_W         = 3;
    localparam int VAL_W         = 32;
    localparam int STATUS_W      = 2;
    localparam int COUNT_W       = 11;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_POP_FRONT  = 3'd1,
        REQ_PUSH_BACK  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_PEEK_FRONT = 3'd4,
        REQ_PEEK_BACK  = 3'd5
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        logic exec;
        logic load_data;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic needs_read;
    } t_dp_status;

endpackage

[hw/rtl/deq_if.sv]
interface deq_req_if;
    logic                                valid;
    logic                                ready;
    logic [deq_pkg::REQ_W-1:0]           req_type;
    logic signed [deq_pkg::VAL_W-1:0]    push_value;

    modport source (output valid, output req_type, output push_value, input ready);
    modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface deq_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [deq_pkg::VAL_W-1:0]    read_value;
    logic [deq_pkg::STATUS_W-1:0]        status;
    logic [deq_pkg::COUNT_W-1:0]         entry_count;

    modport source (output valid, output read_value, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input read_value, input status, input entry_count,
                    output ready);
endinterface

[hw/rtl/deq_ram.sv]
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/deq_ctrl.sv]
module deq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_ready,
    input  deq_pkg::t_dp_status i_status,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output deq_pkg::t_ctrl_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_OUT
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid && r_in_ready) begin
                        r_state    <= S_EXEC;
                        r_in_ready <= 1'b0;
                    end
                end
                S_EXEC: begin
                    if (i_status.needs_read) begin
                        r_state <= S_RDWAIT;
                    end else begin
                        r_state     <= S_OUT;
                        r_out_valid <= 1'b1;
                    end
                end
                S_RDWAIT: begin
                    r_state     <= S_OUT;
                    r_out_valid <= 1'b1;
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b0;
                        r_in_ready  <= 1'b1;
                    end
                end
                default: begin
                    r_state     <= S_IDLE;
                    r_in_ready  <= 1'b1;
                    r_out_valid <= 1'b0;
                end
            endcase
        end
    end

    assign o_in_ready      = r_in_ready;
    assign o_out_valid     = r_out_valid;
    assign o_cmd.latch     = i_in_valid && r_in_ready;
    assign o_cmd.exec      = (r_state == S_EXEC);
    assign o_cmd.load_data = (r_state == S_RDWAIT);

`ifndef SYNTHESIS
    a_ready_xor_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_in_ready && r_out_valid))
        else $error("input ready while a result is pending");
    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && r_in_ready) |=> (r_state == S_EXEC))
        else $error("accepted item did not enter execution");
`endif

endmodule

[hw/rtl/deq_dp.sv]
module deq_dp #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  deq_pkg::t_ctrl_cmd                  i_cmd,
    input  logic [deq_pkg::REQ_W-1:0]           i_req_type,
    input  logic signed [deq_pkg::VAL_W-1:0]    i_push_value,
    output deq_pkg::t_dp_status                 o_status,
    output logic signed [deq_pkg::VAL_W-1:0]    o_read_value,
    output logic [deq_pkg::STATUS_W-1:0]        o_res_status,
    output logic [deq_pkg::COUNT_W-1:0]         o_entry_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    // Latched request.
    logic [deq_pkg::REQ_W-1:0]        r_req;
    logic [deq_pkg::VAL_W-1:0]        r_val;

    // Queue state.
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;

    // Result registers.
    logic [deq_pkg::VAL_W-1:0]        r_read_value;
    deq_pkg::t_status                 r_res_status, n_res_status;
    logic [deq_pkg::COUNT_W-1:0]      r_entry_count;

    logic                             w_wr_en;
    logic [AW-1:0]                    w_wr_addr;
    logic [AW-1:0]                    w_rd_addr;
    logic [deq_pkg::VAL_W-1:0]        w_rd_data;
    logic                             w_needs_read;
    logic                             w_empty;
    logic                             w_full;
    logic [AW-1:0]                    w_head_up, w_head_dn, w_tail_up, w_tail_dn;
    logic [CW+deq_pkg::COUNT_W-1:0]   w_cnt_ext;

    assign w_empty   = (r_count == '0);
    assign w_full    = (r_count == FULL_CNT);
    assign w_head_up = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
    assign w_head_dn = (r_head == '0) ? LAST_IDX : r_head - 1'b1;
    assign w_tail_up = (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;
    assign w_tail_dn = (r_tail == '0) ? LAST_IDX : r_tail - 1'b1;

    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_res_status = deq_pkg::ST_OK;
        w_wr_en      = 1'b0;
        w_wr_addr    = r_tail;
        w_rd_addr    = r_head;
        w_needs_read = 1'b0;
        case (r_req)
            deq_pkg::REQ_PUSH_FRONT: begin
                w_wr_addr = w_head_dn;
                if (w_full) begin
                    n_res_status = deq_pkg::ST_FULL;
                end else begin
                    w_wr_en = i_cmd.exec;
                    n_head  = w_head_dn;
                    n_count = r_count + 1'b1;
                end
            end
            deq_pkg::REQ_PUSH_BACK: begin
                if (w_full) begin
                    n_res_status = deq_pkg::ST_FULL;
                end else begin
                    w_wr_en = i_cmd.exec;
                    n_tail  = w_tail_up;
                    n_count = r_count + 1'b1;
                end
            end
            deq_pkg::REQ_POP_FRONT, deq_pkg::REQ_PEEK_FRONT: begin
                if (w_empty) begin
                    n_res_status = deq_pkg::ST_EMPTY;
                end else begin
                    w_needs_read = 1'b1;
                    if (r_req == deq_pkg::REQ_POP_FRONT) begin
                        n_head  = w_head_up;
                        n_count = r_count - 1'b1;
                    end
                end
            end
            deq_pkg::REQ_POP_BACK, deq_pkg::REQ_PEEK_BACK: begin
                w_rd_addr = w_tail_dn;
                if (w_empty) begin
                    n_res_status = deq_pkg::ST_EMPTY;
                end else begin
                    w_needs_read = 1'b1;
                    if (r_req == deq_pkg::REQ_POP_BACK) begin
                        n_tail  = w_tail_dn;
                        n_count = r_count - 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // The count port is the count after this request, cut to its fixed width.
    assign w_cnt_ext = {{deq_pkg::COUNT_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req <= i_req_type;
            r_val <= i_push_value;
        end
        if (i_cmd.exec) begin
            r_read_value  <= '0;
            r_res_status  <= n_res_status;
            r_entry_count <= w_cnt_ext[deq_pkg::COUNT_W-1:0];
        end else if (i_cmd.load_data) begin
            r_read_value <= w_rd_data;
        end
    end

    deq_ram #(
        .WIDTH (deq_pkg::VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (r_val),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign o_status.needs_read = w_needs_read;
    assign o_read_value        = r_read_value;
    assign o_res_status        = r_res_status;
    assign o_entry_count       = r_entry_count;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count exceeds depth");
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.exec |=> $stable(r_count) && $stable(r_head) && $stable(r_tail))
        else $error("queue state changed outside execution");
    a_no_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> !w_full)
        else $error("write issued to a full queue");
`endif

endmodule

[hw/rtl/double_ended_queue_top.sv]
// Bounded double-ended queue of signed 32-bit values held in a ring buffer.
// Requests arrive on the i_req channel (req_type, push_value) and every
// request gives exactly one item on the o_rsp channel (read_value, status,
// entry_count). Both channels use a valid/ready handshake; an item moves at
// a rising edge where valid and ready are both high.
// Request codes: push front, pop front, push back, pop back, peek front,
// peek back. Pops and peeks on an empty queue answer zero with empty status;
// a push on a full queue is dropped with full status. Unused codes do nothing.
// A push, or an empty or unused request, goes from execution straight to the
// result; a pop or peek that reads the entry store passes through a store
// read state first, because the read port of the store is registered.
// One request is in flight at a time: a new request is taken only after the
// result of the previous one has been accepted, following the sequence of
// the controller (execute, store read, result).
// While the receiver stalls, the result is held stable and no new request is
// accepted. Reset clears the pointers and the count, leaving the queue empty;
// the entry store needs no clearing because only held entries are ever read.
module double_ended_queue_top #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    deq_req_if.sink   i_req,
    deq_rsp_if.source o_rsp
);

    deq_pkg::t_ctrl_cmd  w_cmd;
    deq_pkg::t_dp_status w_status;

    // The controller sequences each request; the datapath owns the queue
    // pointers, the count, the entry store and the result registers.
    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_rsp.ready),
        .i_status    (w_status),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .o_cmd       (w_cmd)
    );

    deq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_req_type    (i_req.req_type),
        .i_push_value  (i_req.push_value),
        .o_status      (w_status),
        .o_read_value  (o_rsp.read_value),
        .o_res_status  (o_rsp.status),
        .o_entry_count (o_rsp.entry_count)
    );

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

// Self-checking testbench for the bounded double-ended queue.
//
// Requests go in on the request channel and every accepted request gives
// exactly one item on the response channel. A shadow deque in this module
// (ring buffer, head and tail indices, held count) is advanced each time a
// request is driven. The expected response is queued at that moment, and a
// checker on the response side compares every accepted response with the
// oldest queued expectation.
//
// The run is split into named tests that are called in turn:
//   - empty-queue requests, value extremes, every request code and index
//     wrap-around at both ends,
//   - a long hold-off on the response side while requests keep coming,
//   - random traffic that starts near empty, fills the queue, keeps it full,
//     and then mixes requests, at the end with no idling on either side.
module tb;

    localparam int DEPTH       = deq_pkg::DEPTH_DEFAULT;
    localparam int MAX_REPORTS = 100;

    // Request codes the block decodes as no operation.
    localparam logic [deq_pkg::REQ_W-1:0] REQ_SPARE_LO = 3'd6;
    localparam logic [deq_pkg::REQ_W-1:0] REQ_SPARE_HI = 3'd7;

    // Expected content of one response item.
    typedef struct packed {
        logic signed [deq_pkg::VAL_W-1:0] read_value;
        deq_pkg::t_status                 status;
        logic [deq_pkg::COUNT_W-1:0]      entry_count;
    } t_deq_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    deq_req_if req_bus ();
    deq_rsp_if rsp_bus ();

    double_ended_queue_top #(
        .DEPTH (DEPTH)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    // Shadow copy of the queue state.
    logic [deq_pkg::VAL_W-1:0] shadow_store [DEPTH];
    int unsigned               shadow_head;
    int unsigned               shadow_tail;
    int unsigned               shadow_count;

    // Responses predicted but not yet seen on the response channel.
    t_deq_result pending_results [$];

    int fail_count = 0;

    // Idle controls. The percentages give the chance that an idle burst
    // starts before a request or in a response cycle.
    int tx_gap_pct   = 0;
    int rx_stall_pct = 0;

    // The test process bumps hold_token to ask the response side for one
    // long hold-off; the response process counts the cycles itself.
    int hold_token = 0;
    int hold_seen  = 0;
    int hold_left  = 0;
    int stall_left = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned ring_up(input int unsigned idx);
        return (idx + 1 >= DEPTH) ? 0 : idx + 1;
    endfunction

    function automatic int unsigned ring_down(input int unsigned idx);
        return (idx == 0) ? DEPTH - 1 : idx - 1;
    endfunction

    // Advances the shadow deque by one request and gives the response that
    // the block owes for it.
    function automatic t_deq_result deque_outcome(input logic [deq_pkg::REQ_W-1:0] code,
                                                  input logic [deq_pkg::VAL_W-1:0] value);
        t_deq_result res;
        int unsigned last;
        res.read_value = '0;
        res.status     = deq_pkg::ST_OK;
        case (code)
            deq_pkg::REQ_PUSH_FRONT: begin
                if (shadow_count >= DEPTH) begin
                    res.status = deq_pkg::ST_FULL;
                end else begin
                    shadow_head = ring_down(shadow_head);
                    shadow_store[shadow_head] = value;
                    shadow_count++;
                end
            end
            deq_pkg::REQ_PUSH_BACK: begin
                if (shadow_count >= DEPTH) begin
                    res.status = deq_pkg::ST_FULL;
                end else begin
                    shadow_store[shadow_tail] = value;
                    shadow_tail = ring_up(shadow_tail);
                    shadow_count++;
                end
            end
            deq_pkg::REQ_POP_FRONT, deq_pkg::REQ_PEEK_FRONT: begin
                if (shadow_count == 0) begin
                    res.status = deq_pkg::ST_EMPTY;
                end else begin
                    res.read_value = shadow_store[shadow_head];
                    if (code == deq_pkg::REQ_POP_FRONT) begin
                        shadow_head = ring_up(shadow_head);
                        shadow_count--;
                    end
                end
            end
            deq_pkg::REQ_POP_BACK, deq_pkg::REQ_PEEK_BACK: begin
                if (shadow_count == 0) begin
                    res.status = deq_pkg::ST_EMPTY;
                end else begin
                    last = ring_down(shadow_tail);
                    res.read_value = shadow_store[last];
                    if (code == deq_pkg::REQ_POP_BACK) begin
                        shadow_tail = last;
                        shadow_count--;
                    end
                end
            end
            default: begin
            end
        endcase
        res.entry_count = shadow_count[deq_pkg::COUNT_W-1:0];
        return res;
    endfunction

    // Offers one request item and returns once it has been accepted. Valid
    // stays high after acceptance so that a following request can go out in
    // the next cycle; it is lowered at the start of an idle burst or by
    // settle_queue when a test ends.
    task automatic send_item(input logic [deq_pkg::REQ_W-1:0] code,
                             input logic [deq_pkg::VAL_W-1:0] value);
        int gap;
        if (tx_gap_pct > 0 && $urandom_range(0, 99) < tx_gap_pct) begin
            gap = $urandom_range(1, 10);
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.req_type   <= code;
        req_bus.push_value <= value;
        pending_results.push_back(deque_outcome(code, value));
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
    endtask

    // Sends one random request. The push and pop shares are given in
    // percent; most of the rest are peeks and a few are unused codes.
    // The value is random for every code, since non-pushes must ignore it.
    task automatic send_weighted(input int push_pct, input int pop_pct);
        int                        pick;
        logic                      back_end;
        logic [deq_pkg::REQ_W-1:0] code;
        pick     = $urandom_range(0, 99);
        back_end = 1'($urandom_range(0, 1));
        if (pick < push_pct) begin
            code = back_end ? deq_pkg::REQ_PUSH_BACK : deq_pkg::REQ_PUSH_FRONT;
        end else if (pick < push_pct + pop_pct) begin
            code = back_end ? deq_pkg::REQ_POP_BACK : deq_pkg::REQ_POP_FRONT;
        end else if (pick < 97) begin
            code = back_end ? deq_pkg::REQ_PEEK_BACK : deq_pkg::REQ_PEEK_FRONT;
        end else begin
            code = back_end ? REQ_SPARE_HI : REQ_SPARE_LO;
        end
        send_item(code, $urandom);
    endtask

    // Picks new idle rates for a stretch of traffic. A zero rate comes up
    // often so that stretches without idling occur on either side.
    task automatic shuffle_idling();
        tx_gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
        rx_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
    endtask

    // Stops offering requests and waits until every predicted response has
    // been seen, then a few more cycles so that a stray extra response
    // would still be caught by the checker.
    task automatic settle_queue();
        req_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Empty-queue requests, unused codes, value extremes at both ends, and
    // index wrap-around in both directions from the reset position.
    task automatic test_directed_edges();
        tx_gap_pct   = 30;
        rx_stall_pct = 30;
        send_item(deq_pkg::REQ_POP_FRONT, 32'h1234_5678);
        send_item(deq_pkg::REQ_POP_BACK, 32'hFFFF_FFFF);
        send_item(deq_pkg::REQ_PEEK_FRONT, 32'h0000_0000);
        send_item(deq_pkg::REQ_PEEK_BACK, 32'h8000_0000);
        send_item(REQ_SPARE_LO, 32'h7FFF_FFFF);
        send_item(REQ_SPARE_HI, 32'hFFFF_FFFF);
        // Head starts at index zero, so this push wraps it to the top entry.
        send_item(deq_pkg::REQ_PUSH_FRONT, 32'h8000_0000);
        send_item(deq_pkg::REQ_PUSH_BACK, 32'h7FFF_FFFF);
        send_item(deq_pkg::REQ_PUSH_FRONT, 32'h0000_0000);
        send_item(deq_pkg::REQ_PUSH_BACK, 32'hFFFF_FFFF);
        send_item(deq_pkg::REQ_PEEK_FRONT, 32'hAAAA_AAAA);
        send_item(deq_pkg::REQ_PEEK_BACK, 32'h5555_5555);
        send_item(REQ_SPARE_HI, 32'h0F0F_0F0F);
        send_item(deq_pkg::REQ_POP_BACK, 32'h0);
        send_item(deq_pkg::REQ_POP_FRONT, 32'h0);
        send_item(deq_pkg::REQ_POP_BACK, 32'h0);
        send_item(deq_pkg::REQ_POP_FRONT, 32'h0);
        send_item(deq_pkg::REQ_POP_FRONT, 32'h0);
        send_item(deq_pkg::REQ_PEEK_BACK, 32'h0);
        // One entry in front of the head, then a pop from the back: the
        // tail has to wrap downward to reach it.
        send_item(deq_pkg::REQ_PUSH_FRONT, 32'hDEAD_BEEF);
        send_item(deq_pkg::REQ_POP_BACK, 32'h0);
        send_item(deq_pkg::REQ_PUSH_BACK, 32'h0BAD_F00D);
        send_item(deq_pkg::REQ_POP_FRONT, 32'h0);
        settle_queue();
    endtask

    // The response side holds off for a long stretch while requests keep
    // coming back to back, so the block must stop taking requests and hold
    // its pending response steady until the stall ends.
    task automatic test_response_holdoff();
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        hold_token++;
        repeat (30) send_weighted(50, 30);
        settle_queue();
    endtask

    // Random traffic: a walk around the empty state, a push-heavy run that
    // fills the queue and keeps pushing against the bound, a mixed stretch,
    // and a final stretch with no idling at all.
    task automatic test_random_traffic();
        int n;
        n = 0;
        repeat (150) begin
            if (n % 50 == 0) shuffle_idling();
            send_weighted(40, 40);
            n++;
        end
        while (shadow_count < DEPTH) begin
            if (n % 50 == 0) shuffle_idling();
            send_weighted(92, 4);
            n++;
        end
        repeat (40) send_weighted(70, 5);
        repeat (250) begin
            if (n % 50 == 0) shuffle_idling();
            send_weighted(45, 45);
            n++;
        end
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        repeat (150) send_weighted(40, 50);
        settle_queue();
    endtask

    // Response side: drives ready, runs the long hold-off when asked, and
    // checks each accepted response against the oldest expectation.
    always @(posedge i_clk) begin : rsp_side
        t_deq_result want;
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                if (pending_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $error("response item with no request outstanding");
                end else begin
                    want = pending_results.pop_front();
                    if (rsp_bus.read_value !== want.read_value) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $error("read_value: expected %0d, actual %0d",
                                   want.read_value, rsp_bus.read_value);
                    end
                    if (rsp_bus.status !== want.status) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $error("status: expected %0d, actual %0d",
                                   want.status, rsp_bus.status);
                    end
                    if (rsp_bus.entry_count !== want.entry_count) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $error("entry_count: expected %0d, actual %0d",
                                   want.entry_count, rsp_bus.entry_count);
                    end
                end
            end

            if (hold_seen != hold_token) begin
                hold_seen = hold_token;
                hold_left = 300;
            end

            if (hold_left > 0) begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rsp_bus.ready <= 1'b0;
            end else if (rx_stall_pct > 0 && $urandom_range(0, 99) < rx_stall_pct) begin
                // This cycle is the first of a burst of stalled cycles; stall_left holds the rest.
                stall_left = $urandom_range(1, 10) - 1;
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    // Main sequence: reset once, then the tests in turn, then the verdict.
    initial begin
        i_rst_n            = 1'b0;
        req_bus.valid      = 1'b0;
        req_bus.req_type   = deq_pkg::REQ_PUSH_FRONT;
        req_bus.push_value = '0;
        shadow_head        = 0;
        shadow_tail        = 0;
        shadow_count       = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_edges();
        test_response_holdoff();
        test_random_traffic();

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog for a hung handshake; far above the slowest correct run.
    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
